[rtl/core/ndg_pkg.sv]
// ndg_pkg: widths, status codes, register indexes and reset values of the
// note dispenser. Used by every module of the block; depends on nothing.

package ndg_pkg;

    // field widths
    localparam int DENOMS     = 6;
    localparam int DENOM_W    = 20;
    localparam int LIMIT_W    = 24;
    localparam int AMOUNT_W   = 24;
    localparam int BAL_W      = 48;
    localparam int IDX_W      = 3;
    localparam int CNT_IN_W   = 10;
    localparam int PAID_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int ADD_W      = CNT_IN_W + DENOM_W;

    // defaults of the top-level parameters
    localparam int DEF_NOTE_KINDS  = 6;
    localparam int DEF_COUNT_WIDTH = 16;

    // limits
    localparam logic [CNT_IN_W-1:0] DEPOSIT_MAX = CNT_IN_W'(500);
    localparam logic [PAID_W-1:0]   PAID_MAX    = {PAID_W{1'b1}};
    localparam logic [BAL_W-1:0]    BAL_MAX     = {BAL_W{1'b1}};

    // configuration reset values
    localparam logic [DENOM_W-1:0] DENOM_RESET [DENOMS] = '{
        DENOM_W'(10000), DENOM_W'(20000), DENOM_W'(50000),
        DENOM_W'(100000), DENOM_W'(200000), DENOM_W'(500000)
    };
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10000000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = CFG_IDX_W'(6);

    // operations
    localparam logic OP_DEPOSIT  = 1'b0;
    localparam logic OP_WITHDRAW = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAL_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_AMOUNT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OVER_LIMIT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVER_BALANCE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CASSETTE_LOW = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOT_PAYABLE  = 3'd6;
    localparam logic [STATUS_W-1:0] ST_BAD_COUNT    = 3'd7;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[rtl/core/ndg_div.sv]
// ndg_div: restoring divider, one quotient bit per cycle, for the greedy
// note count (remainder over denomination). Depends on ndg_pkg.

module ndg_div
    import ndg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [AMOUNT_W-1:0] i_dividend,
    input  logic [DENOM_W-1:0]  i_divisor,
    output t_div_stat           o_stat,
    output logic [AMOUNT_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(AMOUNT_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_steps;

    logic [DENOM_W-1:0]  r_rem;
    logic [AMOUNT_W-1:0] r_quo;
    logic [DENOM_W-1:0]  r_div;

    logic [DENOM_W:0]   w_shift;
    logic [DENOM_W+1:0] w_diff;
    logic               w_bit;
    logic [DENOM_W-1:0] n_rem;

    // one trial subtraction per cycle
    always_comb begin
        w_shift = {r_rem, r_quo[AMOUNT_W-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_div};
        w_bit   = ~w_diff[DENOM_W+1];
        n_rem   = w_bit ? w_diff[DENOM_W-1:0] : w_shift[DENOM_W-1:0];
    end

    // step counter and handshake toward the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_steps <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_steps <= STEP_W'(AMOUNT_W);
            end else if (r_busy) begin
                r_steps <= r_steps - STEP_W'(1);
                if (r_steps == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[AMOUNT_W-2:0], w_bit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

[rtl/core/ndg_mul.sv]
// ndg_mul: registered multiplier shared by deposit value, cassette total
// and greedy remainder update. Depends on ndg_pkg.

module ndg_mul
    import ndg_pkg::*;
#(
    parameter int A_W = DEF_COUNT_WIDTH
) (
    input  logic                   i_clk,
    input  logic [A_W-1:0]         i_a,
    input  logic [DENOM_W-1:0]     i_b,
    output logic [A_W+DENOM_W-1:0] o_prod
);

    logic [A_W+DENOM_W-1:0] r_prod;

    // product is registered and ready in the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_prod <= (A_W+DENOM_W)'(i_a) * (A_W+DENOM_W)'(i_b);
    end

    assign o_prod = r_prod;

endmodule

[rtl/core/note_dispense_greedy_top.sv]
// note_dispense_greedy_top: note cassette with deposit and greedy withdrawal
// sequencer. Depends on ndg_pkg, ndg_div and ndg_mul.
//
//   channel  | direction | handshake                    | payload
//   ---------+-----------+------------------------------+---------------------------
//   in       | into      | i_in_valid / o_in_stall      | operation, denom, count, amount, balance
//   out      | out of    | o_out_valid / i_out_stall    | status, paid_0..5, new_balance
//   cfg      | into      | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// A deposit passes the check, multiply and add states before its result; a withdrawal
// refused by the early checks goes from the check to the result, and one that runs the
// greedy first sums the cassette total (a multiply and an accumulate per kind), then
// makes up to K + ... + 1 denomination visits over all restarts (K = number of kinds).
// The serial divider (one quotient bit per cycle) sets the per-denomination cost.
// Reset (synchronous) empties the cassette and loads the default denominations.
// An item is taken only while the sequencer is idle; a finished result waits
// in the output register while the next item is taken.

module note_dispense_greedy_top
    import ndg_pkg::*;
#(
    parameter int NOTE_KINDS  = DEF_NOTE_KINDS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_operation,
    input  logic [IDX_W-1:0]      i_denom_index,
    input  logic [CNT_IN_W-1:0]   i_note_count,
    input  logic [AMOUNT_W-1:0]   i_amount,
    input  logic [BAL_W-1:0]      i_balance,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [STATUS_W-1:0]   o_status,
    output logic [PAID_W-1:0]     o_paid_0,
    output logic [PAID_W-1:0]     o_paid_1,
    output logic [PAID_W-1:0]     o_paid_2,
    output logic [PAID_W-1:0]     o_paid_3,
    output logic [PAID_W-1:0]     o_paid_4,
    output logic [PAID_W-1:0]     o_paid_5,
    output logic [BAL_W-1:0]      o_new_balance,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int KINDS_USED = (NOTE_KINDS < DENOMS) ? NOTE_KINDS : DENOMS;
    localparam int KIND_W     = $clog2(KINDS_USED);
    localparam int MUL_A_W    = (COUNT_WIDTH > PAID_W) ? COUNT_WIDTH : PAID_W;
    localparam int PROD_W     = MUL_A_W + DENOM_W;
    localparam int TOT_W      = PROD_W + KIND_W;
    localparam int SUM_W      = ((COUNT_WIDTH > CNT_IN_W) ? COUNT_WIDTH : CNT_IN_W) + 1;

    localparam logic [KIND_W-1:0]      LAST_KIND = KIND_W'(KINDS_USED - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_DEP_MUL = 4'd2;
    localparam logic [3:0] S_DEP_ADD = 4'd3;
    localparam logic [3:0] S_TOT_MUL = 4'd4;
    localparam logic [3:0] S_TOT_ACC = 4'd5;
    localparam logic [3:0] S_TOT_CMP = 4'd6;
    localparam logic [3:0] S_PASS    = 4'd7;
    localparam logic [3:0] S_STEP    = 4'd8;
    localparam logic [3:0] S_DIV     = 4'd9;
    localparam logic [3:0] S_MUL     = 4'd10;
    localparam logic [3:0] S_SUB     = 4'd11;
    localparam logic [3:0] S_NEXT    = 4'd12;
    localparam logic [3:0] S_DONE    = 4'd13;

    // control state
    logic [3:0]             r_state;
    logic                   r_out_valid;
    logic [DENOM_W-1:0]     r_denom [DENOMS];
    logic [LIMIT_W-1:0]     r_limit;
    logic [COUNT_WIDTH-1:0] r_count [KINDS_USED];
    logic [KIND_W-1:0]      r_k;
    logic [KIND_W-1:0]      r_s;

    // item and working registers
    logic                r_op;
    logic [IDX_W-1:0]    r_idx;
    logic [CNT_IN_W-1:0] r_cnt;
    logic [AMOUNT_W-1:0] r_amount;
    logic [BAL_W-1:0]    r_bal;
    logic [STATUS_W-1:0] r_status;
    logic [BAL_W-1:0]    r_nb;
    logic [TOT_W-1:0]    r_total;
    logic [AMOUNT_W-1:0] r_rem;
    logic [PAID_W-1:0]   r_num;
    logic [PAID_W-1:0]   r_take [DENOMS];

    // output register
    logic [STATUS_W-1:0] r_out_status;
    logic [PAID_W-1:0]   r_out_paid [DENOMS];
    logic [BAL_W-1:0]    r_out_nb;

    // shared units
    logic                div_start;
    t_div_stat           div_stat;
    logic [AMOUNT_W-1:0] div_quo;
    logic [MUL_A_W-1:0]  mul_a;
    logic [PROD_W-1:0]   mul_prod;

    logic [DENOM_W-1:0]     denom_k;
    logic [COUNT_WIDTH-1:0] count_k;
    logic [MUL_A_W-1:0]     count_ext;
    logic [PAID_W-1:0]      cap_k;
    logic [PAID_W-1:0]      n_num;
    logic                   w_use;
    logic                   w_dep_bad;
    logic [STATUS_W-1:0]    w_check_status;
    logic [SUM_W-1:0]       n_dep_sum;
    logic [COUNT_WIDTH-1:0] n_dep_count;
    logic [BAL_W:0]         n_dep_bal;
    logic                   pass_exact;
    logic                   out_free;
    logic                   pay_out;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    // selected denomination and note count
    always_comb begin
        denom_k   = r_denom[r_k];
        count_k   = r_count[r_k];
        count_ext = MUL_A_W'(count_k);
        cap_k     = (count_ext > MUL_A_W'(PAID_MAX)) ? PAID_MAX : count_ext[PAID_W-1:0];
        n_num     = (div_quo < AMOUNT_W'(cap_k)) ? div_quo[PAID_W-1:0] : cap_k;
        w_use     = (denom_k != '0) && (r_rem >= AMOUNT_W'(denom_k)) && (count_k != '0);
        div_start = (r_state == S_STEP) && w_use;
    end

    // early checks of the latched item
    always_comb begin
        w_dep_bad = (r_idx >= IDX_W'(KINDS_USED)) || (r_cnt == '0) || (r_cnt > DEPOSIT_MAX);
        if (r_op == OP_DEPOSIT) begin
            w_check_status = w_dep_bad ? ST_BAD_COUNT : ST_OK;
        end else if (r_bal == '0) begin
            w_check_status = ST_BAL_EMPTY;
        end else if (r_amount == '0) begin
            w_check_status = ST_ZERO_AMOUNT;
        end else if (r_amount > r_limit) begin
            w_check_status = ST_OVER_LIMIT;
        end else if (BAL_W'(r_amount) > r_bal) begin
            w_check_status = ST_OVER_BALANCE;
        end else begin
            w_check_status = ST_OK;
        end
    end

    // deposit arithmetic with saturation
    always_comb begin
        n_dep_sum   = SUM_W'(count_k) + SUM_W'(r_cnt);
        n_dep_count = (n_dep_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX
                                                      : n_dep_sum[COUNT_WIDTH-1:0];
        n_dep_bal   = {1'b0, r_bal} + (BAL_W+1)'(mul_prod[ADD_W-1:0]);
    end

    // multiplier operand select
    always_comb begin
        case (r_state)
            S_DEP_MUL: mul_a = MUL_A_W'(r_cnt);
            S_MUL:     mul_a = MUL_A_W'(r_num);
            default:   mul_a = count_ext;
        endcase
    end

    assign pass_exact = (r_state == S_NEXT) && (r_k == '0) && (r_rem == '0);
    assign pay_out    = (r_status == ST_OK) && (r_op == OP_WITHDRAW);

    ndg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_rem),
        .i_divisor  (denom_k),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    ndg_mul #(
        .A_W (MUL_A_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (denom_k),
        .o_prod (mul_prod)
    );

    // sequencer, configuration and cassette counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_limit     <= LIMIT_RESET;
            r_k         <= '0;
            r_s         <= '0;
            for (int i = 0; i < DENOMS; i++) begin
                r_denom[i] <= DENOM_RESET[i];
            end
            for (int i = 0; i < KINDS_USED; i++) begin
                r_count[i] <= '0;
            end
        end else begin
            // configuration write
            if (i_cfg_valid) begin
                if (i_cfg_index < CFG_IDX_W'(DENOMS)) begin
                    r_denom[i_cfg_index] <= i_cfg_data[DENOM_W-1:0];
                end else if (i_cfg_index == CFG_LIMIT) begin
                    r_limit <= i_cfg_data[LIMIT_W-1:0];
                end
            end

            // result taken downstream, unless a new one is loaded this cycle
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_check_status != ST_OK) begin
                        r_state <= S_DONE;
                    end else if (r_op == OP_DEPOSIT) begin
                        r_k     <= r_idx[KIND_W-1:0];
                        r_state <= S_DEP_MUL;
                    end else begin
                        r_k     <= '0;
                        r_state <= S_TOT_MUL;
                    end
                end
                S_DEP_MUL: r_state <= S_DEP_ADD;
                S_DEP_ADD: begin
                    r_count[r_k] <= n_dep_count;
                    r_state      <= S_DONE;
                end
                S_TOT_MUL: r_state <= S_TOT_ACC;
                S_TOT_ACC: begin
                    if (r_k == LAST_KIND) begin
                        r_state <= S_TOT_CMP;
                    end else begin
                        r_k     <= r_k + KIND_W'(1);
                        r_state <= S_TOT_MUL;
                    end
                end
                S_TOT_CMP: begin
                    if (r_total < TOT_W'(r_amount)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_s     <= LAST_KIND;
                        r_state <= S_PASS;
                    end
                end
                S_PASS: begin
                    r_k     <= r_s;
                    r_state <= S_STEP;
                end
                S_STEP: r_state <= w_use ? S_DIV : S_NEXT;
                S_DIV: begin
                    if (div_stat.done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_SUB;
                S_SUB: r_state <= S_NEXT;
                S_NEXT: begin
                    if (r_k != '0) begin
                        r_k     <= r_k - KIND_W'(1);
                        r_state <= S_STEP;
                    end else if (r_rem == '0) begin
                        for (int i = 0; i < KINDS_USED; i++) begin
                            r_count[i] <= r_count[i] - COUNT_WIDTH'(r_take[i]);
                        end
                        r_state <= S_DONE;
                    end else if (r_s == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_s     <= r_s - KIND_W'(1);
                        r_state <= S_PASS;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_op     <= i_operation;
                    r_idx    <= i_denom_index;
                    r_cnt    <= i_note_count;
                    r_amount <= i_amount;
                    r_bal    <= i_balance;
                end
            end
            S_CHECK: begin
                r_status <= w_check_status;
                r_nb     <= r_bal;
                r_total  <= '0;
            end
            S_DEP_ADD: begin
                r_nb <= n_dep_bal[BAL_W] ? BAL_MAX : n_dep_bal[BAL_W-1:0];
            end
            S_TOT_ACC: r_total <= r_total + TOT_W'(mul_prod);
            S_TOT_CMP: begin
                if (r_total < TOT_W'(r_amount)) begin
                    r_status <= ST_CASSETTE_LOW;
                end
            end
            S_PASS: begin
                r_rem <= r_amount;
                for (int i = 0; i < DENOMS; i++) begin
                    r_take[i] <= '0;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    r_num       <= n_num;
                    r_take[r_k] <= n_num;
                end
            end
            S_SUB: r_rem <= r_rem - mul_prod[AMOUNT_W-1:0];
            S_NEXT: begin
                if (r_k == '0) begin
                    if (r_rem == '0) begin
                        r_status <= ST_OK;
                        r_nb     <= r_bal - BAL_W'(r_amount);
                    end else if (r_s == '0) begin
                        r_status <= ST_NOT_PAYABLE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_out_status <= r_status;
                    r_out_nb     <= r_nb;
                    for (int i = 0; i < DENOMS; i++) begin
                        r_out_paid[i] <= pay_out ? r_take[i] : '0;
                    end
                end
            end
            default: r_rem <= r_rem;
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_paid_0      = r_out_paid[0];
    assign o_paid_1      = r_out_paid[1];
    assign o_paid_2      = r_out_paid[2];
    assign o_paid_3      = r_out_paid[3];
    assign o_paid_4      = r_out_paid[4];
    assign o_paid_5      = r_out_paid[5];
    assign o_new_balance = r_out_nb;

    // divider is only started when free and never on a zero denomination
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (!div_stat.busy && denom_k != '0))
        else $error("divider started while busy or with zero divisor");

    // a refused item dispenses no notes
    a_paid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |->
        ((o_paid_0 | o_paid_1 | o_paid_2 | o_paid_3 | o_paid_4 | o_paid_5) == '0))
        else $error("notes paid on a refused item");

    // the greedy remainder never grows
    a_rem_falls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUB) |=> (r_rem <= $past(r_rem)))
        else $error("greedy remainder grew");

    // an exact pass lowers the balance
    a_pay_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pass_exact |=> (r_nb < r_bal && r_state == S_DONE))
        else $error("exact pass did not lower the balance");

endmodule
